/* hw/rtl/qov_pkg.sv */
// Package for the quadrature odometry and velocity block.
// Holds item and command types, arithmetic constants and the 4x step decoder.
// No dependencies.
package qov_pkg;

  localparam int MM_W      = 24;
  localparam int IV_W      = 24;
  localparam int SPD_W     = 24;
  localparam int TOT_W     = 32;
  localparam int MSCALE_W  = 38;        // mm_per_count * 15625
  localparam int MM_RESET  = 6554;
  localparam int MM_SCALE  = 15625;     // 1e6 / 256 = 15625 / 4
  localparam int MIN_INTERVAL = 100;
  localparam int ALPHA_Q16 = 22938;
  localparam int KEEP_Q16  = 42598;
  localparam int ROUND_HALF = 32768;
  localparam int QUO_W     = 24;
  localparam int DIV_W     = 26;        // divisor is 4 * interval_us
  localparam int MAG_LIM_W = 40;        // count magnitude capped at 2^39
  localparam int EMA_W     = 42;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] KIND_LEFT  = 2'd0;
  localparam logic [1:0] KIND_RIGHT = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  typedef enum logic [2:0] {
    CMD_LEFT  = 3'd0,
    CMD_RIGHT = 3'd1,
    CMD_TICK  = 3'd2,
    CMD_SKIP  = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_op_t;

  typedef enum logic [1:0] {
    STEP_NONE = 2'b00,
    STEP_UP   = 2'b01,
    STEP_DOWN = 2'b10
  } step_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic            enc_a;
    logic            enc_b;
    logic [IV_W-1:0] interval_us;
    logic            left_off;
    logic            right_off;
    logic            driver_off;
  } qov_in_t;

  typedef struct packed {
    logic signed [TOT_W-1:0] left_total;
    logic signed [TOT_W-1:0] right_total;
    logic signed [SPD_W-1:0] left_speed;
    logic signed [SPD_W-1:0] right_speed;
    logic                    tick_skipped;
  } qov_out_t;

  typedef struct packed {
    cmd_op_t         op;
    step_t           step;
    logic [IV_W-1:0] iv;
    logic            l_off;
    logic            r_off;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic                    start;
    logic                    neg;
    logic [IV_W-1:0]         iv;
    logic signed [SPD_W-1:0] filt;
    logic [MSCALE_W-1:0]     mscale;
  } spd_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [SPD_W-1:0] speed;
  } spd_rsp_t;

  // standard 4x quadrature transition table
  function automatic step_t step_of(input logic [1:0] old_ph, input logic [1:0] new_ph);
    step_t s;
    case ({old_ph, new_ph})
      4'd2, 4'd4, 4'd11, 4'd13: s = STEP_UP;
      4'd1, 4'd7, 4'd8, 4'd14:  s = STEP_DOWN;
      default:                  s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

/* hw/rtl/quadrature_odometry_velocity_top.sv */
// Top level of the two-wheel quadrature odometry and velocity block.
// Instantiates qov_front, qov_fifo and qov_back. Depends on qov_pkg.
//
// Encoder samples, clear items and short (skipped) ticks are handled in the idle
// state of the back end and stream at one transfer per clock, while results are
// accepted and no tick is in progress, through a two-entry command queue and an
// output register. A velocity tick occupies the back end while each wheel goes in
// turn through one shared speed unit made of a bit-serial multiplier over the
// capped count magnitude, a restoring divider and an EMA update. The front end
// keeps taking items into the queue while a tick is computed, until it is full.
// mm_per_count is loaded through cfg_wr_en/cfg_wr_data; it resets to 6554.
module quadrature_odometry_velocity_top import qov_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [MM_W-1:0] cfg_wr_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  qov_in_t         in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output qov_out_t        out_data
);

  fifo_stat_t q_stat;
  logic       q_push, q_pop;
  cmd_t       push_cmd, head_cmd;

  qov_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  qov_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  qov_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_stat      (q_stat),
    .q_cmd       (head_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

/* hw/rtl/qov_front.sv */
// Front end: accepts items, decodes encoder phases and classifies ticks.
// Pushes one command per item into the queue. Depends on qov_pkg.
module qov_front import qov_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  qov_in_t    in_data,
  input  fifo_stat_t q_stat,
  output logic       q_push,
  output cmd_t       q_cmd
);

  logic [1:0] phl_r, phl_nxt;
  logic [1:0] phr_r, phr_nxt;
  logic [1:0] new_ph;

  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && !q_stat.full;
  assign new_ph   = {in_data.enc_a, in_data.enc_b};

  always_comb begin
    phl_nxt     = phl_r;
    phr_nxt     = phr_r;
    q_cmd.op    = CMD_CLEAR;
    q_cmd.step  = STEP_NONE;
    q_cmd.iv    = in_data.interval_us;
    q_cmd.l_off = in_data.left_off || in_data.driver_off;
    q_cmd.r_off = in_data.right_off || in_data.driver_off;
    case (in_data.kind)
      KIND_LEFT: begin
        q_cmd.op   = CMD_LEFT;
        q_cmd.step = step_of(phl_r, new_ph);
        if (q_push) phl_nxt = new_ph;
      end
      KIND_RIGHT: begin
        q_cmd.op   = CMD_RIGHT;
        q_cmd.step = step_of(phr_r, new_ph);
        if (q_push) phr_nxt = new_ph;
      end
      KIND_TICK: begin
        if (in_data.interval_us <= IV_W'(MIN_INTERVAL)) q_cmd.op = CMD_SKIP;
        else q_cmd.op = CMD_TICK;
      end
      KIND_CLEAR: begin
        q_cmd.op = CMD_CLEAR;
        if (q_push) begin
          phl_nxt = '0;
          phr_nxt = '0;
        end
      end
      default: q_cmd.op = CMD_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phl_r <= '0;
      phr_r <= '0;
    end else begin
      phl_r <= phl_nxt;
      phr_r <= phr_nxt;
    end
  end

endmodule

/* hw/rtl/qov_fifo.sv */
// Short command queue between front and back end.
// Register storage, one read port. Depends on qov_pkg.
module qov_fifo import qov_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cmd_t       push_cmd,
  input  logic       pop,
  output cmd_t       head_cmd,
  output fifo_stat_t stat
);

  cmd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* hw/rtl/qov_speed.sv */
// Shared wheel speed unit: serial multiply, restoring divide, EMA update.
// speed = EMA(sat(mag * mm * 15625 / (4 * iv))). Depends on qov_pkg.
module qov_speed import qov_pkg::*; #(
  parameter int MAG_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  spd_req_t         req,
  input  logic [MAG_W-1:0] req_mag,
  output spd_rsp_t         rsp
);

  localparam int P_W   = MAG_W + MSCALE_W;
  localparam int HI_W  = P_W - QUO_W;
  localparam int CNT_W = ($clog2(MAG_W) > 5) ? $clog2(MAG_W) : 5;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_CHK  = 6'b000100,
    S_DIV  = 6'b001000,
    S_EMA1 = 6'b010000,
    S_EMA2 = 6'b100000
  } spd_state_t;

  spd_state_t              st_r, st_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    done_r, done_nxt;
  logic [MAG_W-1:0]        mag_r, mag_nxt;
  logic [P_W-1:0]          prod_r, prod_nxt;
  logic [MSCALE_W-1:0]     mscale_r, mscale_nxt;
  logic [DIV_W-1:0]        div_r, div_nxt;
  logic [DIV_W-1:0]        rem_r, rem_nxt;
  logic [QUO_W-1:0]        quo_r, quo_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    neg_r, neg_nxt;
  logic signed [SPD_W-1:0] filt_r, filt_nxt;
  logic signed [EMA_W-1:0] p1_r, p1_nxt;
  logic signed [SPD_W-1:0] res_r, res_nxt;

  logic [HI_W-1:0]         hi;
  logic [DIV_W:0]          trial, trial_sub;
  logic                    ge;
  logic [QUO_W-1:0]        lim, mag_q;
  logic signed [SPD_W-1:0] raw;
  logic signed [EMA_W-1:0] ema_sum;

  assign hi        = prod_r[P_W-1:QUO_W];
  assign trial     = {rem_r, prod_r[QUO_W-1]};
  assign ge        = trial >= {1'b0, div_r};
  assign trial_sub = trial - {1'b0, div_r};
  // negative results saturate one further than positive ones
  assign lim       = neg_r ? QUO_W'(1 << (SPD_W - 1)) : QUO_W'((1 << (SPD_W - 1)) - 1);
  assign mag_q     = (ovf_r || quo_r > lim) ? lim : quo_r;
  assign raw       = neg_r ? $signed(~mag_q + 1'b1) : $signed(mag_q);
  assign ema_sum   = p1_r + EMA_W'(filt_r) * EMA_W'(KEEP_Q16) + EMA_W'(ROUND_HALF);

  assign rsp.done  = done_r;
  assign rsp.speed = res_r;

  always_comb begin
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    mag_nxt    = mag_r;
    prod_nxt   = prod_r;
    mscale_nxt = mscale_r;
    div_nxt    = div_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    ovf_nxt    = ovf_r;
    neg_nxt    = neg_r;
    filt_nxt   = filt_r;
    p1_nxt     = p1_r;
    res_nxt    = res_r;
    case (st_r)
      S_IDLE: begin
        if (req.start) begin
          mag_nxt    = req_mag;
          mscale_nxt = req.mscale;
          div_nxt    = {req.iv, 2'b00};
          neg_nxt    = req.neg;
          filt_nxt   = req.filt;
          prod_nxt   = '0;
          cnt_nxt    = CNT_W'(MAG_W - 1);
          st_nxt     = S_MUL;
        end
      end
      S_MUL: begin
        // MSB-first shift and add
        prod_nxt = {prod_r[P_W-2:0], 1'b0} + (mag_r[MAG_W-1] ? P_W'(mscale_r) : '0);
        mag_nxt  = {mag_r[MAG_W-2:0], 1'b0};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) st_nxt = S_CHK;
      end
      S_CHK: begin
        // quotient needs more than QUO_W bits: saturated anyway
        ovf_nxt = hi >= HI_W'(div_r);
        rem_nxt = hi[DIV_W-1:0];
        quo_nxt = '0;
        cnt_nxt = CNT_W'(QUO_W - 1);
        st_nxt  = (hi >= HI_W'(div_r)) ? S_EMA1 : S_DIV;
      end
      S_DIV: begin
        rem_nxt  = ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
        quo_nxt  = {quo_r[QUO_W-2:0], ge};
        prod_nxt = {prod_r[P_W-2:0], 1'b0};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) st_nxt = S_EMA1;
      end
      S_EMA1: begin
        p1_nxt = EMA_W'(raw) * EMA_W'(ALPHA_Q16);
        st_nxt = S_EMA2;
      end
      S_EMA2: begin
        // weights sum to one, so the result cannot leave the Q16.8 range
        res_nxt  = ema_sum[SPD_W+15:16];
        done_nxt = 1'b1;
        st_nxt   = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    mag_r    <= mag_nxt;
    prod_r   <= prod_nxt;
    mscale_r <= mscale_nxt;
    div_r    <= div_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    ovf_r    <= ovf_nxt;
    neg_r    <= neg_nxt;
    filt_r   <= filt_nxt;
    p1_r     <= p1_nxt;
    res_r    <= res_nxt;
  end

endmodule

/* hw/rtl/qov_back.sv */
// Back end: wheel counts, tick sequencing, filtered speeds, result register.
// Instantiates qov_speed. Depends on qov_pkg.
module qov_back import qov_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [MM_W-1:0] cfg_wr_data,
  input  fifo_stat_t      q_stat,
  input  cmd_t            q_cmd,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output qov_out_t        out_data
);

  localparam int MAG_W = (COUNT_BITS > MAG_LIM_W) ? MAG_LIM_W : COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] MAG_CAP =
    (COUNT_BITS > MAG_LIM_W) ? (COUNT_BITS'(1) << (MAG_LIM_W - 1)) : '1;

  typedef enum logic [4:0] {
    B_IDLE   = 5'b00001,
    B_LSTART = 5'b00010,
    B_LWAIT  = 5'b00100,
    B_RSTART = 5'b01000,
    B_RWAIT  = 5'b10000
  } back_state_t;

  back_state_t             st_r, st_nxt;
  logic [COUNT_BITS-1:0]   acc_l_r, acc_l_nxt, acc_r_r, acc_r_nxt;
  logic [COUNT_BITS-1:0]   prev_l_r, prev_l_nxt, prev_r_r, prev_r_nxt;
  logic signed [SPD_W-1:0] filt_l_r, filt_l_nxt, filt_r_r, filt_r_nxt;
  logic [MSCALE_W-1:0]     mscale_r, mscale_nxt;
  logic                    out_valid_r, out_valid_nxt;
  qov_out_t                out_r, out_nxt;
  logic [MAG_W-1:0]        mag_l_r, mag_l_nxt, mag_rw_r, mag_rw_nxt;
  logic                    neg_l_r, neg_l_nxt, neg_rw_r, neg_rw_nxt;
  logic                    off_l_r, off_l_nxt, off_rw_r, off_rw_nxt;
  logic [IV_W-1:0]         iv_r, iv_nxt;

  logic                    take;
  logic                    emit, emit_skip;
  logic [MAG_W:0]          wl, wr;
  spd_req_t                spd_req;
  logic [MAG_W-1:0]        spd_mag;
  spd_rsp_t                spd_rsp;

  // {sign of delta, capped magnitude}
  function automatic logic [MAG_W:0] wheel_mag(input logic [COUNT_BITS-1:0] cur,
                                               input logic [COUNT_BITS-1:0] prev);
    logic [COUNT_BITS-1:0] d;
    logic [COUNT_BITS-1:0] full;
    d    = cur - prev;
    full = d[COUNT_BITS-1] ? (~d + 1'b1) : d;
    if (full > MAG_CAP) full = MAG_CAP;
    return {d[COUNT_BITS-1], MAG_W'(full)};
  endfunction

  assign wl        = wheel_mag(acc_l_r, prev_l_r);
  assign wr        = wheel_mag(acc_r_r, prev_r_r);
  assign take      = (st_r == B_IDLE) && !q_stat.empty && (!out_valid_r || out_ready);
  assign q_pop     = take;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign spd_req.start  = (st_r == B_LSTART) || (st_r == B_RSTART);
  assign spd_req.neg    = (st_r == B_RSTART) ? neg_rw_r : neg_l_r;
  assign spd_req.filt   = (st_r == B_RSTART) ? filt_r_r : filt_l_r;
  assign spd_req.iv     = iv_r;
  assign spd_req.mscale = mscale_r;
  assign spd_mag        = (st_r == B_RSTART) ? mag_rw_r : mag_l_r;

  qov_speed #(.MAG_W(MAG_W)) u_speed (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (spd_req),
    .req_mag (spd_mag),
    .rsp     (spd_rsp)
  );

  always_comb begin
    st_nxt     = st_r;
    acc_l_nxt  = acc_l_r;
    acc_r_nxt  = acc_r_r;
    prev_l_nxt = prev_l_r;
    prev_r_nxt = prev_r_r;
    filt_l_nxt = filt_l_r;
    filt_r_nxt = filt_r_r;
    mag_l_nxt  = mag_l_r;
    mag_rw_nxt = mag_rw_r;
    neg_l_nxt  = neg_l_r;
    neg_rw_nxt = neg_rw_r;
    off_l_nxt  = off_l_r;
    off_rw_nxt = off_rw_r;
    iv_nxt     = iv_r;
    emit       = 1'b0;
    emit_skip  = 1'b0;
    mscale_nxt = cfg_wr_en ? MSCALE_W'(cfg_wr_data) * MSCALE_W'(MM_SCALE) : mscale_r;

    case (st_r)
      B_IDLE: begin
        if (take) begin
          case (q_cmd.op)
            CMD_LEFT: begin
              if (q_cmd.step == STEP_UP) acc_l_nxt = acc_l_r + 1'b1;
              else if (q_cmd.step == STEP_DOWN) acc_l_nxt = acc_l_r - 1'b1;
              emit = 1'b1;
            end
            CMD_RIGHT: begin
              if (q_cmd.step == STEP_UP) acc_r_nxt = acc_r_r + 1'b1;
              else if (q_cmd.step == STEP_DOWN) acc_r_nxt = acc_r_r - 1'b1;
              emit = 1'b1;
            end
            CMD_SKIP: begin
              emit      = 1'b1;
              emit_skip = 1'b1;
            end
            CMD_TICK: begin
              mag_l_nxt  = wl[MAG_W-1:0];
              neg_l_nxt  = wl[MAG_W];
              mag_rw_nxt = wr[MAG_W-1:0];
              neg_rw_nxt = !wr[MAG_W];   // right wheel counts the other way
              off_l_nxt  = q_cmd.l_off;
              off_rw_nxt = q_cmd.r_off;
              iv_nxt     = q_cmd.iv;
              st_nxt     = B_LSTART;
            end
            CMD_CLEAR: begin
              acc_l_nxt  = '0;
              acc_r_nxt  = '0;
              prev_l_nxt = '0;
              prev_r_nxt = '0;
              filt_l_nxt = '0;
              filt_r_nxt = '0;
              emit       = 1'b1;
            end
            default: emit = 1'b1;
          endcase
        end
      end
      B_LSTART: st_nxt = B_LWAIT;
      B_LWAIT: begin
        if (spd_rsp.done) begin
          filt_l_nxt = off_l_r ? '0 : spd_rsp.speed;
          st_nxt     = B_RSTART;
        end
      end
      B_RSTART: st_nxt = B_RWAIT;
      B_RWAIT: begin
        if (spd_rsp.done) begin
          filt_r_nxt = off_rw_r ? '0 : spd_rsp.speed;
          prev_l_nxt = acc_l_r;
          prev_r_nxt = acc_r_r;
          emit       = 1'b1;    // slot was free when the tick was popped
          st_nxt     = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase

    out_nxt.left_total   = TOT_W'(acc_l_nxt);
    out_nxt.right_total  = TOT_W'(acc_r_nxt);
    out_nxt.left_speed   = filt_l_nxt;
    out_nxt.right_speed  = filt_r_nxt;
    out_nxt.tick_skipped = emit_skip;
    if (!emit) out_nxt = out_r;

    out_valid_nxt = emit ? 1'b1 : (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
      acc_l_r     <= '0;
      acc_r_r     <= '0;
      prev_l_r    <= '0;
      prev_r_r    <= '0;
      filt_l_r    <= '0;
      filt_r_r    <= '0;
      mscale_r    <= MSCALE_W'(MM_RESET * MM_SCALE);
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      acc_l_r     <= acc_l_nxt;
      acc_r_r     <= acc_r_nxt;
      prev_l_r    <= prev_l_nxt;
      prev_r_r    <= prev_r_nxt;
      filt_l_r    <= filt_l_nxt;
      filt_r_r    <= filt_r_nxt;
      mscale_r    <= mscale_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r    <= out_nxt;
    mag_l_r  <= mag_l_nxt;
    mag_rw_r <= mag_rw_nxt;
    neg_l_r  <= neg_l_nxt;
    neg_rw_r <= neg_rw_nxt;
    off_l_r  <= off_l_nxt;
    off_rw_r <= off_rw_nxt;
    iv_r     <= iv_nxt;
  end

endmodule

/* hw/rtl/qov_checker.sv */
// Port-level checker for quadrature_odometry_velocity_top, with its bind.
// Depends on qov_pkg.
module qov_checker import qov_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input qov_out_t        out_data
);

  qov_out_t last_r;
  logic     seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) last_r <= out_data;
  end

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("stalled result changed");

  // a skipped tick leaves counts and speeds as the previous result showed
  a_skip_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.tick_skipped && seen_r |->
      out_data.left_total == last_r.left_total &&
      out_data.right_total == last_r.right_total &&
      out_data.left_speed == last_r.left_speed &&
      out_data.right_speed == last_r.right_speed)
    else $error("skipped tick changed state");

endmodule

bind quadrature_odometry_velocity_top qov_checker u_qov_checker (.*);
